[rtl/pcrs_pkg.sv]
// Shared types and constants for the packet classify, reply and steer core.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package pcrs_pkg;

  localparam logic [15:0] ETH_ARP        = 16'h0806;
  localparam logic [15:0] ETH_IPV4       = 16'h0800;
  localparam logic [15:0] ARP_REQUEST    = 16'd1;
  localparam logic [15:0] ARP_REPLY      = 16'd2;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ICMP_ECHO_REQ  = 16'h0800;
  localparam logic [7:0]  ICMP_ECHO_REP  = 8'h00;
  localparam logic [15:0] SUM_MASK       = 16'hFFFF;

  localparam int NUM_PORT_REGS = 4;
  localparam int CFG_DATA_W    = 48;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_MAC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_IP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_B     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_C     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_D     = 3'd7;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CHUNK_W = 8;
  localparam int FRAME_W = 64;
  localparam int NSTEP   = FRAME_W / CHUNK_W;
  localparam int STEP_CW = $clog2(NSTEP + 1);

  typedef enum logic [1:0] {
    ACT_DROP  = 2'd0,
    ACT_REPLY = 2'd1,
    ACT_FWD   = 2'd2
  } act_e;

  typedef struct packed {
    act_e         action;
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [31:0]  sender_ip;
    logic [31:0]  target_ip;
    logic [47:0]  target_mac;
    logic [15:0]  arp_op;
    logic [7:0]   reply_type;
    logic [15:0]  icmp_sum;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    act_e         action;
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [31:0]  sender_ip;
    logic [31:0]  target_ip;
    logic [47:0]  target_mac;
    logic [15:0]  arp_op;
    logic [7:0]   reply_type;
    logic [15:0]  icmp_sum;
    logic [3:0]   ring_index;
  } result_t;

endpackage

`default_nettype wire

[rtl/pcrs_front.sv]
// Front end: classifies one header summary per request and builds the queue entry.
// Depends on pcrs_pkg.
`default_nettype none

module pcrs_front #(
  parameter int MAX_PORTS = 4
) (
  input  wire logic                    in_valid_i,
  input  wire logic                    q_full_i,
  input  wire logic [15:0]             ether_kind_i,
  input  wire logic [47:0]             dst_mac_i,
  input  wire logic [47:0]             src_mac_i,
  input  wire logic [15:0]             arp_op_i,
  input  wire logic [7:0]              ip_proto_i,
  input  wire logic [31:0]             sender_ip_i,
  input  wire logic [31:0]             target_ip_i,
  input  wire logic [47:0]             arp_sender_mac_i,
  input  wire logic [15:0]             icmp_type_code_i,
  input  wire logic [15:0]             icmp_sum_i,
  input  wire logic [15:0]             udp_port_i,
  input  wire logic [63:0]             frame_number_i,
  input  wire logic [47:0]             device_mac_i,
  input  wire logic [31:0]             device_ip_i,
  input  wire logic [2:0]              port_count_i,
  input  wire logic [pcrs_pkg::NUM_PORT_REGS-1:0][15:0] ports_i,
  output logic                         push_o,
  output pcrs_pkg::entry_t             entry_o
);
  import pcrs_pkg::*;

  logic        port_hit;
  logic [16:0] sum0;
  logic [16:0] sum1;
  logic [16:0] sum2;

  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    port_hit = 1'b0;
    for (int i = 0; i < NUM_PORT_REGS; i++) begin
      if (i < MAX_PORTS && i < int'(port_count_i) && ports_i[i] == udp_port_i) begin
        port_hit = 1'b1;
      end
    end
  end

  // ones' complement update for type 8 -> 0
  always_comb begin
    sum0 = {1'b0, ~icmp_sum_i} + {1'b0, ~ICMP_ECHO_REQ & SUM_MASK};
    sum1 = {1'b0, sum0[15:0]} + {16'd0, sum0[16]};
    sum2 = {1'b0, sum1[15:0]} + {16'd0, sum1[16]};
  end

  always_comb begin
    entry_o       = '0;
    entry_o.frame = frame_number_i;
    if (ether_kind_i == ETH_ARP) begin
      if (arp_op_i == ARP_REQUEST && target_ip_i == device_ip_i) begin
        entry_o.action     = ACT_REPLY;
        entry_o.dst_mac    = src_mac_i;
        entry_o.src_mac    = device_mac_i;
        entry_o.sender_ip  = device_ip_i;
        entry_o.target_ip  = sender_ip_i;
        entry_o.target_mac = arp_sender_mac_i;
        entry_o.arp_op     = ARP_REPLY;
      end
    end else if (ether_kind_i == ETH_IPV4) begin
      if (ip_proto_i == PROTO_ICMP) begin
        if (icmp_type_code_i == ICMP_ECHO_REQ) begin
          entry_o.action     = ACT_REPLY;
          entry_o.dst_mac    = src_mac_i;
          entry_o.src_mac    = dst_mac_i;
          entry_o.sender_ip  = target_ip_i;
          entry_o.target_ip  = sender_ip_i;
          entry_o.reply_type = ICMP_ECHO_REP;
          entry_o.icmp_sum   = ~sum2[15:0];
        end
      end else if (ip_proto_i == PROTO_UDP) begin
        if (port_hit) begin
          entry_o.action = ACT_FWD;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pcrs_queue.sv]
// Short FIFO of classified entries between the front and back ends.
// Depends on pcrs_pkg.
`default_nettype none

module pcrs_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  pcrs_pkg::entry_t push_data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output pcrs_pkg::entry_t pop_data_o,
  output logic             empty_o
);
  import pcrs_pkg::*;

  entry_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [QCW-1:0]   count_q;
  logic [QCW-1:0]   count_d;

  assign full_o     = count_q == QCW'(QDEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pcrs_back.sv]
// Back end: ring steering remainder over eight byte steps, and the result register.
// Depends on pcrs_pkg.
`default_nettype none

module pcrs_back #(
  parameter int MAX_RINGS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_empty_i,
  input  pcrs_pkg::entry_t q_data_i,
  output logic             pop_o,
  input  wire logic [4:0]  ring_count_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pcrs_pkg::result_t result_o
);
  import pcrs_pkg::*;

  localparam int DW = $clog2(MAX_RINGS + 1);

  entry_t               cur_q;
  entry_t               load_w;
  logic                 busy_q;
  logic [STEP_CW-1:0]   cnt_q;
  logic [DW-1:0]        rem_q;
  logic [DW-1:0]        rc_w;
  logic [DW+3:0]        rem_ext;
  logic                 fin_w;
  logic                 out_free_w;
  logic                 move_w;
  result_t              out_q;
  logic                 out_valid_q;

  function automatic logic [DW-1:0] mod_step(input logic [DW-1:0] r,
                                             input logic [CHUNK_W-1:0] b,
                                             input logic [DW-1:0] d);
    logic [DW:0]   t;
    logic [DW-1:0] acc;
    acc = r;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      t = {acc, b[i]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      acc = t[DW-1:0];
    end
    return acc;
  endfunction

  always_comb begin
    if (ring_count_i == '0) begin
      rc_w = DW'(1);
    end else if (int'(ring_count_i) > MAX_RINGS) begin
      rc_w = DW'(MAX_RINGS);
    end else begin
      rc_w = DW'(ring_count_i);
    end
  end

  always_comb begin
    load_w       = q_data_i;
    load_w.frame = q_data_i.frame << CHUNK_W;
  end

  assign fin_w      = busy_q && (cur_q.action != ACT_FWD || cnt_q == STEP_CW'(NSTEP));
  assign out_free_w = !out_valid_q || !out_stall_i;
  assign move_w     = fin_w && out_free_w;
  assign pop_o      = !q_empty_i && (!busy_q || move_w);
  assign rem_ext    = {4'd0, rem_q};

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q       <= load_w;
      rem_q       <= mod_step('0, q_data_i.frame[FRAME_W-1 -: CHUNK_W], rc_w);
    end else if (busy_q && !fin_w) begin
      cur_q.frame <= cur_q.frame << CHUNK_W;
      rem_q       <= mod_step(rem_q, cur_q.frame[FRAME_W-1 -: CHUNK_W], rc_w);
    end
    if (move_w) begin
      out_q.action     <= cur_q.action;
      out_q.dst_mac    <= cur_q.dst_mac;
      out_q.src_mac    <= cur_q.src_mac;
      out_q.sender_ip  <= cur_q.sender_ip;
      out_q.target_ip  <= cur_q.target_ip;
      out_q.target_mac <= cur_q.target_mac;
      out_q.arp_op     <= cur_q.arp_op;
      out_q.reply_type <= cur_q.reply_type;
      out_q.icmp_sum   <= cur_q.icmp_sum;
      out_q.ring_index <= (cur_q.action == ACT_FWD) ? rem_ext[3:0] : 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_CW'(1);
      end else begin
        if (move_w) begin
          busy_q <= 1'b0;
        end
        if (busy_q && !fin_w) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (move_w) begin
        out_valid_q <= 1'b1;
      end else if (out_free_w) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_step_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !fin_w |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("remainder step counter did not advance");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cur_q.action == ACT_FWD |-> rem_q < rc_w)
    else $error("partial remainder not below ring count");

  a_ring_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action != ACT_FWD |-> out_q.ring_index == 4'd0)
    else $error("ring index set on a non-forward result");

  a_no_early_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cur_q.action == ACT_FWD && cnt_q != STEP_CW'(NSTEP) |-> !pop_o)
    else $error("entry popped while remainder still in progress");

endmodule

`default_nettype wire

[rtl/packet_classify_reply_steer_core.sv]
// Top level of the packet classify, reply and steer core: configuration registers,
// front end, entry queue and back end. Depends on pcrs_pkg, pcrs_front, pcrs_queue, pcrs_back.
//
// One header summary in, one result out per request. ARP requests for the device IP
// and ICMP echo requests come back as replies, UDP frames to an accepted port are
// steered to ring frame number mod ring_count (clamped to 1..MAX_RINGS), everything else
// is dropped. The front end classifies in the accept cycle and writes a two-entry queue,
// so it keeps taking requests while the back end works. Replies and drops leave the back
// end at one per cycle while the output is not stalled; a forwarded frame occupies the
// back end until the byte-serial remainder unit, folding 8 bits of the 64-bit frame number
// per cycle, is done. Results pass the queue and the back end's entry and result registers.
// Configuration registers may only be written while no request is in flight.
`default_nettype none

module packet_classify_reply_steer_core #(
  parameter int MAX_PORTS = 4,
  parameter int MAX_RINGS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] ether_kind_i,
  input  wire logic [47:0] dst_mac_i,
  input  wire logic [47:0] src_mac_i,
  input  wire logic [15:0] arp_op_i,
  input  wire logic [7:0]  ip_proto_i,
  input  wire logic [31:0] sender_ip_i,
  input  wire logic [31:0] target_ip_i,
  input  wire logic [47:0] arp_sender_mac_i,
  input  wire logic [15:0] icmp_type_code_i,
  input  wire logic [15:0] icmp_sum_i,
  input  wire logic [15:0] udp_port_i,
  input  wire logic [63:0] frame_number_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       action_o,
  output logic [47:0]      out_dst_mac_o,
  output logic [47:0]      out_src_mac_o,
  output logic [31:0]      out_sender_ip_o,
  output logic [31:0]      out_target_ip_o,
  output logic [47:0]      out_target_mac_o,
  output logic [15:0]      out_arp_op_o,
  output logic [7:0]       out_icmp_type_o,
  output logic [15:0]      out_icmp_sum_o,
  output logic [3:0]       ring_index_o
);
  import pcrs_pkg::*;

  logic [47:0]                      device_mac_q;
  logic [31:0]                      device_ip_q;
  logic [4:0]                       ring_count_q;
  logic [2:0]                       port_count_q;
  logic [NUM_PORT_REGS-1:0][15:0]   port_q;

  logic    push_w;
  logic    full_w;
  logic    empty_w;
  logic    pop_w;
  entry_t  entry_w;
  entry_t  head_w;
  result_t result_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_mac_q <= '0;
      device_ip_q  <= '0;
      ring_count_q <= 5'd1;
      port_count_q <= '0;
      port_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEVICE_MAC: device_mac_q <= cfg_data_i;
        CFG_DEVICE_IP:  device_ip_q  <= cfg_data_i[31:0];
        CFG_RING_COUNT: ring_count_q <= cfg_data_i[4:0];
        CFG_PORT_COUNT: port_count_q <= cfg_data_i[2:0];
        CFG_PORT_A:     port_q[0]    <= cfg_data_i[15:0];
        CFG_PORT_B:     port_q[1]    <= cfg_data_i[15:0];
        CFG_PORT_C:     port_q[2]    <= cfg_data_i[15:0];
        CFG_PORT_D:     port_q[3]    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = full_w;

  pcrs_front #(
    .MAX_PORTS(MAX_PORTS)
  ) u_front (
    .in_valid_i       (in_valid_i),
    .q_full_i         (full_w),
    .ether_kind_i     (ether_kind_i),
    .dst_mac_i        (dst_mac_i),
    .src_mac_i        (src_mac_i),
    .arp_op_i         (arp_op_i),
    .ip_proto_i       (ip_proto_i),
    .sender_ip_i      (sender_ip_i),
    .target_ip_i      (target_ip_i),
    .arp_sender_mac_i (arp_sender_mac_i),
    .icmp_type_code_i (icmp_type_code_i),
    .icmp_sum_i       (icmp_sum_i),
    .udp_port_i       (udp_port_i),
    .frame_number_i   (frame_number_i),
    .device_mac_i     (device_mac_q),
    .device_ip_i      (device_ip_q),
    .port_count_i     (port_count_q),
    .ports_i          (port_q),
    .push_o           (push_w),
    .entry_o          (entry_w)
  );

  pcrs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_w),
    .push_data_i (entry_w),
    .full_o      (full_w),
    .pop_i       (pop_w),
    .pop_data_o  (head_w),
    .empty_o     (empty_w)
  );

  pcrs_back #(
    .MAX_RINGS(MAX_RINGS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty_w),
    .q_data_i     (head_w),
    .pop_o        (pop_w),
    .ring_count_i (ring_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_w)
  );

  assign action_o         = result_w.action;
  assign out_dst_mac_o    = result_w.dst_mac;
  assign out_src_mac_o    = result_w.src_mac;
  assign out_sender_ip_o  = result_w.sender_ip;
  assign out_target_ip_o  = result_w.target_ip;
  assign out_target_mac_o = result_w.target_mac;
  assign out_arp_op_o     = result_w.arp_op;
  assign out_icmp_type_o  = result_w.reply_type;
  assign out_icmp_sum_o   = result_w.icmp_sum;
  assign ring_index_o     = result_w.ring_index;

endmodule

`default_nettype wire
